// ===== src/ssw_pkg.sv =====
// Shared types and constants for the SMBIOS structure walker.
// No dependencies; imported by every module of the walker.
package ssw_pkg;

   localparam int unsigned QueueDepthDefault = 2;
   localparam int unsigned NumFields = 10;

   // Command codes on req_op
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   // Configuration register indexes
   localparam logic CSR_TABLE_LENGTH    = 1'b0;
   localparam logic CSR_STRUCTURE_LIMIT = 1'b1;

   // Structure types with extra fields
   localparam logic [7:0] TYPE_PROCESSOR = 8'd4;
   localparam logic [7:0] TYPE_CACHE     = 8'd7;

   // Structure offsets of captured bytes
   localparam logic [8:0] OFF_CACHE_SIZE_LO = 9'h009;
   localparam logic [8:0] OFF_CACHE_SIZE_HI = 9'h00a;
   localparam logic [8:0] OFF_CACHE_KIND    = 9'h011;
   localparam logic [8:0] OFF_SOCKET        = 9'h019;
   localparam logic [8:0] OFF_L3_HI         = 9'h01f;
   localparam logic [8:0] OFF_SATURATE      = 9'h100;

   // Slots of the captured byte array
   localparam int unsigned SLOT_SIZE_LO = 0;
   localparam int unsigned SLOT_SIZE_HI = 1;
   localparam int unsigned SLOT_KIND    = 2;
   localparam int unsigned SLOT_SOCKET  = 3;
   localparam int unsigned SLOT_L1      = 4;
   localparam int unsigned SLOT_L2      = 6;
   localparam int unsigned SLOT_L3      = 8;

   localparam logic [7:0] SOCKET_FIRST = 8'h0f;
   localparam logic [7:0] SOCKET_LAST  = 8'h15;
   localparam logic [7:0] SOCKET_BIAS  = 8'h0e;
   localparam logic [7:0] KIND_FIRST   = 8'd3;
   localparam logic [7:0] KIND_LAST    = 8'd5;
   localparam logic [7:0] KIND_BIAS    = 8'd2;
   localparam logic [15:0] NO_HANDLE   = 16'hffff;
   localparam logic [7:0] MIN_HEADER   = 8'd4;

   typedef enum logic [1:0] {
      REC_COMPLETE  = 2'd0,
      REC_TRUNCATED = 2'd1,
      REC_EMPTY     = 2'd2
   } rec_kind_type;

   // One record as it leaves the parser, before field decoding
   typedef struct packed {
      rec_kind_type kind;
      logic         last;
      logic [7:0]   stype;
      logic [15:0]  handle;
      logic [NumFields-1:0][7:0] fld;
   } rec_type;

endpackage

// ===== src/ssw_front.sv =====
// Byte parser of the SMBIOS structure walker: tracks position, header and string set.
// Depends on ssw_pkg; pushes one rec_type per finished structure into the queue.
module ssw_front
   import ssw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        req_op,
   input  logic [7:0]  req_table_byte,
   input  logic [15:0] table_length,
   input  logic [15:0] structure_limit,
   output logic        push,
   output rec_type     push_rec
);

   logic [15:0] pos_ff, pos_in;
   logic [8:0]  off_ff, off_in;
   logic [7:0]  hlen_ff, hlen_in;
   logic [7:0]  htype_ff, htype_in;
   logic [15:0] hhandle_ff, hhandle_in;
   logic        pzero_ff, pzero_in;
   logic [15:0] seen_ff, seen_in;
   logic [NumFields-1:0][7:0] cap_ff, cap_in;
   logic        done_ff, done_in;

   logic [7:0]  hlen_new, htype_new, len_eff;
   logic [15:0] hhandle_new, seen_new;
   logic [NumFields-1:0][7:0] cap_new;
   logic [16:0] next_pos;
   logic        complete, last_byte, last, short_table;

   always_comb begin
      htype_new   = (off_ff == 9'd0) ? req_table_byte : htype_ff;
      hlen_new    = (off_ff == 9'd1) ? req_table_byte : hlen_ff;
      hhandle_new = hhandle_ff;
      if (off_ff == 9'd2) begin
         hhandle_new[7:0] = req_table_byte;
      end
      if (off_ff == 9'd3) begin
         hhandle_new[15:8] = req_table_byte;
      end
      cap_new = cap_ff;
      if (off_ff == OFF_CACHE_SIZE_LO) begin
         cap_new[SLOT_SIZE_LO] = req_table_byte;
      end
      if (off_ff == OFF_CACHE_SIZE_HI) begin
         cap_new[SLOT_SIZE_HI] = req_table_byte;
      end
      if (off_ff == OFF_CACHE_KIND) begin
         cap_new[SLOT_KIND] = req_table_byte;
      end
      for (int i = 0; i < 7; i++) begin
         if (off_ff == OFF_SOCKET + 9'(i)) begin
            cap_new[SLOT_SOCKET + i] = req_table_byte;
         end
      end
      len_eff     = (hlen_new < MIN_HEADER) ? MIN_HEADER : hlen_new;
      complete    = (req_table_byte == 8'd0) && pzero_ff;
      next_pos    = {1'b0, pos_ff} + 17'd1;
      last_byte   = next_pos >= {1'b0, table_length};
      seen_new    = seen_ff + 16'd1;
      // fewer than four bytes left after this one, or limit reached
      last        = ((next_pos + 17'd4) > {1'b0, table_length}) ||
                    (seen_new >= structure_limit);
      short_table = (table_length < 16'd4) || (structure_limit == 16'd0);
   end

   always_comb begin
      pos_in     = pos_ff;
      off_in     = off_ff;
      hlen_in    = hlen_ff;
      htype_in   = htype_ff;
      hhandle_in = hhandle_ff;
      pzero_in   = pzero_ff;
      seen_in    = seen_ff;
      cap_in     = cap_ff;
      done_in    = done_ff;
      push       = 1'b0;
      push_rec   = '{kind: REC_EMPTY, last: 1'b1, stype: 8'd0, handle: 16'd0, fld: '0};
      if (accept) begin
         if (req_op == OP_BEGIN) begin
            pos_in     = '0;
            seen_in    = '0;
            off_in     = '0;
            hlen_in    = '0;
            htype_in   = '0;
            hhandle_in = '0;
            pzero_in   = 1'b0;
            cap_in     = '0;
            done_in    = short_table;
            push       = short_table;
         end else if (!done_ff) begin
            hlen_in    = hlen_new;
            htype_in   = htype_new;
            hhandle_in = hhandle_new;
            cap_in     = cap_new;
            if (complete) begin
               push     = 1'b1;
               push_rec = '{kind: REC_COMPLETE, last: last, stype: htype_new,
                            handle: hhandle_new, fld: cap_new};
               seen_in    = seen_new;
               off_in     = '0;
               hlen_in    = '0;
               htype_in   = '0;
               hhandle_in = '0;
               pzero_in   = 1'b0;
               cap_in     = '0;
               pos_in     = next_pos[15:0];
               done_in    = last;
            end else if (last_byte) begin
               push     = 1'b1;
               push_rec = '{kind: REC_TRUNCATED, last: 1'b1, stype: htype_new,
                            handle: hhandle_new, fld: '0};
               done_in  = 1'b1;
            end else begin
               // a zero inside the string set arms the terminator check
               pzero_in = (req_table_byte == 8'd0) && (off_ff >= {1'b0, len_eff});
               off_in   = (off_ff < OFF_SATURATE) ? off_ff + 9'd1 : OFF_SATURATE;
               pos_in   = next_pos[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         off_ff     <= '0;
         hlen_ff    <= '0;
         htype_ff   <= '0;
         hhandle_ff <= '0;
         pzero_ff   <= 1'b0;
         seen_ff    <= '0;
         cap_ff     <= '0;
         done_ff    <= 1'b1;
      end else begin
         pos_ff     <= pos_in;
         off_ff     <= off_in;
         hlen_ff    <= hlen_in;
         htype_ff   <= htype_in;
         hhandle_ff <= hhandle_in;
         pzero_ff   <= pzero_in;
         seen_ff    <= seen_in;
         cap_ff     <= cap_in;
         done_ff    <= done_in;
      end
   end

endmodule

// ===== src/ssw_queue.sv =====
// Short record queue between the parser and the formatter.
// Depends on ssw_pkg for rec_type; depth set by the top level.
module ssw_queue
   import ssw_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepthDefault
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output rec_type head_rec
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   rec_type mem [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == CntFull);
   assign head_valid = (count_ff != '0);
   assign head_rec   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/ssw_back.sv =====
// Record formatter: decodes processor and cache fields and holds the result register.
// Depends on ssw_pkg; drains the record queue into the rsp_ channel.
module ssw_back
   import ssw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  rec_type     head_rec,
   output logic        pop,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [1:0]  rsp_record_kind,
   output logic        rsp_last_of_table,
   output logic [7:0]  rsp_struct_type,
   output logic [15:0] rsp_struct_handle,
   output logic [2:0]  rsp_socket_code,
   output logic [15:0] rsp_l1_cache_handle,
   output logic [15:0] rsp_l2_cache_handle,
   output logic [15:0] rsp_l3_cache_handle,
   output logic [1:0]  rsp_cache_kind,
   output logic [20:0] rsp_cache_size_kb
);

   logic        valid_ff;
   logic [1:0]  kind_ff, kind_in;
   logic        last_ff, last_in;
   logic [7:0]  stype_ff, stype_in;
   logic [15:0] handle_ff, handle_in;
   logic [2:0]  socket_ff, socket_in;
   logic [15:0] l1_ff, l1_in, l2_ff, l2_in, l3_ff, l3_in;
   logic [1:0]  ckind_ff, ckind_in;
   logic [20:0] size_ff, size_in;

   logic        load, is_complete;
   logic [7:0]  sock_byte, kind_byte;
   logic [15:0] size_word;

   // take a new record whenever the result register is free or being taken
   assign load = !valid_ff || !rsp_stall;
   assign pop  = head_valid && load;

   always_comb begin
      is_complete = (head_rec.kind == REC_COMPLETE);
      sock_byte   = head_rec.fld[SLOT_SOCKET];
      kind_byte   = head_rec.fld[SLOT_KIND];
      size_word   = {head_rec.fld[SLOT_SIZE_HI], head_rec.fld[SLOT_SIZE_LO]};
      kind_in     = head_rec.kind;
      last_in     = head_rec.last;
      stype_in    = head_rec.stype;
      handle_in   = head_rec.handle;
      socket_in   = '0;
      l1_in       = NO_HANDLE;
      l2_in       = NO_HANDLE;
      l3_in       = NO_HANDLE;
      ckind_in    = '0;
      size_in     = '0;
      if (is_complete && head_rec.stype == TYPE_PROCESSOR) begin
         if (sock_byte >= SOCKET_FIRST && sock_byte <= SOCKET_LAST) begin
            socket_in = 3'(sock_byte - SOCKET_BIAS);
         end
         l1_in = {head_rec.fld[SLOT_L1 + 1], head_rec.fld[SLOT_L1]};
         l2_in = {head_rec.fld[SLOT_L2 + 1], head_rec.fld[SLOT_L2]};
         l3_in = {head_rec.fld[SLOT_L3 + 1], head_rec.fld[SLOT_L3]};
      end else if (is_complete && head_rec.stype == TYPE_CACHE) begin
         if (kind_byte >= KIND_FIRST && kind_byte <= KIND_LAST) begin
            ckind_in = 2'(kind_byte - KIND_BIAS);
         end
         // granularity bit selects 64K units
         size_in = size_word[15] ? {size_word[14:0], 6'd0} : {6'd0, size_word[14:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= kind_in;
         last_ff   <= last_in;
         stype_ff  <= stype_in;
         handle_ff <= handle_in;
         socket_ff <= socket_in;
         l1_ff     <= l1_in;
         l2_ff     <= l2_in;
         l3_ff     <= l3_in;
         ckind_ff  <= ckind_in;
         size_ff   <= size_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_record_kind     = kind_ff;
   assign rsp_last_of_table   = last_ff;
   assign rsp_struct_type     = stype_ff;
   assign rsp_struct_handle   = handle_ff;
   assign rsp_socket_code     = socket_ff;
   assign rsp_l1_cache_handle = l1_ff;
   assign rsp_l2_cache_handle = l2_ff;
   assign rsp_l3_cache_handle = l3_ff;
   assign rsp_cache_kind      = ckind_ff;
   assign rsp_cache_size_kb   = size_ff;

endmodule

// ===== src/smbios_structure_walker.sv =====
// SMBIOS structure walker: one table byte or begin command per cycle on req_.
// A record reaches rsp_ from the byte that ends its structure by way of the parser
// into the record queue, then the formatter's result register.
// Throughput: one item per cycle while req_stall is low; req_stall rises only while the record queue is full.
// Reset (synchronous): both registers read 0, queue and result register empty,
// the walker ignores bytes until a begin command.
module smbios_structure_walker
   import ssw_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_table_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_record_kind,
   output logic        rsp_last_of_table,
   output logic [7:0]  rsp_struct_type,
   output logic [15:0] rsp_struct_handle,
   output logic [2:0]  rsp_socket_code,
   output logic [15:0] rsp_l1_cache_handle,
   output logic [15:0] rsp_l2_cache_handle,
   output logic [15:0] rsp_l3_cache_handle,
   output logic [1:0]  rsp_cache_kind,
   output logic [20:0] rsp_cache_size_kb
);

   logic [15:0] table_length_ff, structure_limit_ff;
   logic        accept, push, pop, full, head_valid;
   rec_type     push_rec, head_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff    <= '0;
         structure_limit_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TABLE_LENGTH:    table_length_ff    <= csr_wr_data;
            CSR_STRUCTURE_LIMIT: structure_limit_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   ssw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_op          (req_op),
      .req_table_byte  (req_table_byte),
      .table_length    (table_length_ff),
      .structure_limit (structure_limit_ff),
      .push            (push),
      .push_rec        (push_rec)
   );

   ssw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   ssw_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_rec            (head_rec),
      .pop                 (pop),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_record_kind     (rsp_record_kind),
      .rsp_last_of_table   (rsp_last_of_table),
      .rsp_struct_type     (rsp_struct_type),
      .rsp_struct_handle   (rsp_struct_handle),
      .rsp_socket_code     (rsp_socket_code),
      .rsp_l1_cache_handle (rsp_l1_cache_handle),
      .rsp_l2_cache_handle (rsp_l2_cache_handle),
      .rsp_l3_cache_handle (rsp_l3_cache_handle),
      .rsp_cache_kind      (rsp_cache_kind),
      .rsp_cache_size_kb   (rsp_cache_size_kb)
   );

endmodule

// ===== tb/sv/smbios_record_checker.sv =====
// Record checker for the SMBIOS structure walker: predicts each record from the
// accepted items and register writes, then compares what leaves rsp_.
// Depends on ssw_pkg for codes, offsets and slot numbers.
module smbios_record_checker
   import ssw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_table_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_record_kind,
   input  logic        rsp_last_of_table,
   input  logic [7:0]  rsp_struct_type,
   input  logic [15:0] rsp_struct_handle,
   input  logic [2:0]  rsp_socket_code,
   input  logic [15:0] rsp_l1_cache_handle,
   input  logic [15:0] rsp_l2_cache_handle,
   input  logic [15:0] rsp_l3_cache_handle,
   input  logic [1:0]  rsp_cache_kind,
   input  logic [20:0] rsp_cache_size_kb,
   output int          fail_count,
   output int          records_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      rec_kind_type kind;
      logic         last;
      logic [7:0]   stype;
      logic [15:0]  handle;
      logic [2:0]   socket;
      logic [15:0]  l1;
      logic [15:0]  l2;
      logic [15:0]  l3;
      logic [1:0]   ckind;
      logic [20:0]  size_kb;
   } walk_record_type;

   walk_record_type records_due[$];

   // walker state as seen from outside
   logic [15:0] tbl_len, struct_lim, tbl_pos, n_structs, hdr_handle;
   logic [8:0]  offs;
   logic [7:0]  hdr_len, hdr_type;
   logic        prev_zero, walk_idle;
   logic [7:0]  field_bytes [0:10];

   initial begin
      fail_count = 0;
      records_owed = 0;
   end

   function automatic walk_record_type blank_record(rec_kind_type kind, logic [7:0] stype,
                                                    logic [15:0] handle);
      walk_record_type r;
      r.kind = kind;
      r.last = 1'b1;
      r.stype = stype;
      r.handle = handle;
      r.socket = '0;
      r.l1 = NO_HANDLE;
      r.l2 = NO_HANDLE;
      r.l3 = NO_HANDLE;
      r.ckind = '0;
      r.size_kb = '0;
      return r;
   endfunction

   function automatic int field_slot(logic [8:0] off);
      if (off == OFF_CACHE_SIZE_LO) return SLOT_SIZE_LO;
      if (off == OFF_CACHE_SIZE_HI) return SLOT_SIZE_HI;
      if (off == OFF_CACHE_KIND) return SLOT_KIND;
      if (off >= OFF_SOCKET && off <= OFF_L3_HI) return int'(off - OFF_SOCKET) + SLOT_SOCKET;
      return -1;
   endfunction

   task automatic clear_structure();
      offs = '0;
      hdr_len = '0;
      hdr_type = '0;
      hdr_handle = '0;
      prev_zero = 1'b0;
      foreach (field_bytes[i]) field_bytes[i] = '0;
   endtask

   task automatic advance_walk(logic op, logic [7:0] b);
      walk_record_type r;
      logic [16:0]  next_pos, remaining;
      logic [7:0]   len_eff;
      logic [15:0]  size_word;
      int           slot;
      logic         last;
      if (op == OP_BEGIN) begin
         tbl_pos = '0;
         n_structs = '0;
         clear_structure();
         if (tbl_len < MIN_HEADER || struct_lim == 0) begin
            walk_idle = 1'b1;
            records_due.push_back(blank_record(REC_EMPTY, '0, '0));
         end else begin
            walk_idle = 1'b0;
         end
         return;
      end
      // drop bytes until the next begin
      if (walk_idle) return;

      case (offs)
         9'd0: hdr_type = b;
         9'd1: hdr_len = b;
         9'd2: hdr_handle[7:0] = b;
         9'd3: hdr_handle[15:8] = b;
         default: ;
      endcase
      slot = field_slot(offs);
      if (slot >= 0) field_bytes[slot] = b;

      len_eff = (hdr_len < MIN_HEADER) ? MIN_HEADER : hdr_len;
      next_pos = tbl_pos + 17'd1;

      if (b == 8'h00 && prev_zero) begin
         remaining = (tbl_len > next_pos) ? tbl_len - next_pos : '0;
         n_structs = n_structs + 16'd1;
         last = (remaining < MIN_HEADER) || (n_structs >= struct_lim);
         r = blank_record(REC_COMPLETE, hdr_type, hdr_handle);
         r.last = last;
         if (hdr_type == TYPE_PROCESSOR) begin
            if (field_bytes[SLOT_SOCKET] >= SOCKET_FIRST && field_bytes[SLOT_SOCKET] <= SOCKET_LAST)
               r.socket = 3'(field_bytes[SLOT_SOCKET] - SOCKET_BIAS);
            r.l1 = {field_bytes[SLOT_L1 + 1], field_bytes[SLOT_L1]};
            r.l2 = {field_bytes[SLOT_L2 + 1], field_bytes[SLOT_L2]};
            r.l3 = {field_bytes[SLOT_L3 + 1], field_bytes[SLOT_L3]};
         end else if (hdr_type == TYPE_CACHE) begin
            if (field_bytes[SLOT_KIND] >= KIND_FIRST && field_bytes[SLOT_KIND] <= KIND_LAST)
               r.ckind = 2'(field_bytes[SLOT_KIND] - KIND_BIAS);
            size_word = {field_bytes[SLOT_SIZE_HI], field_bytes[SLOT_SIZE_LO]};
            // granularity bit set: size counts 64 KB units
            if (size_word[15]) r.size_kb = {size_word[14:0], 6'd0};
            else r.size_kb = {6'd0, size_word[14:0]};
         end
         records_due.push_back(r);
         clear_structure();
         tbl_pos = next_pos[15:0];
         if (last) walk_idle = 1'b1;
      end else if (next_pos >= tbl_len) begin
         records_due.push_back(blank_record(REC_TRUNCATED, hdr_type, hdr_handle));
         walk_idle = 1'b1;
      end else begin
         // only zeros inside the string set can start the closing pair
         prev_zero = (b == 8'h00) && (offs >= len_eff);
         if (offs < OFF_SATURATE) offs = offs + 9'd1;
         tbl_pos = next_pos[15:0];
      end
   endtask

   task automatic compare_field(string name, logic [20:0] want, logic [20:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      walk_record_type want;
      if (reset) begin
         tbl_len = '0;
         struct_lim = '0;
         tbl_pos = '0;
         n_structs = '0;
         clear_structure();
         walk_idle = 1'b1;
         records_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (records_due.size() == 0) begin
               $error("record with none expected: kind %0d type 0x%0h handle 0x%0h",
                      rsp_record_kind, rsp_struct_type, rsp_struct_handle);
               fail_count++;
            end else begin
               want = records_due.pop_front();
               compare_field("record_kind", want.kind, rsp_record_kind);
               compare_field("last_of_table", want.last, rsp_last_of_table);
               compare_field("struct_type", want.stype, rsp_struct_type);
               compare_field("struct_handle", want.handle, rsp_struct_handle);
               compare_field("socket_code", want.socket, rsp_socket_code);
               compare_field("l1_cache_handle", want.l1, rsp_l1_cache_handle);
               compare_field("l2_cache_handle", want.l2, rsp_l2_cache_handle);
               compare_field("l3_cache_handle", want.l3, rsp_l3_cache_handle);
               compare_field("cache_kind", want.ckind, rsp_cache_kind);
               compare_field("cache_size_kb", want.size_kb, rsp_cache_size_kb);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TABLE_LENGTH:    tbl_len = csr_wr_data;
               CSR_STRUCTURE_LIMIT: struct_lim = csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) advance_walk(req_op, req_table_byte);
      end
      records_owed = records_due.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the SMBIOS structure walker bench: clock, reset, register writes,
// table stimulus and receiver stalls; verdict from smbios_record_checker.
// Depends on ssw_pkg and the smbios_structure_walker RTL.
module tb
   import ssw_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HoldCycles  = 60;
   localparam int DrainCycles = 4;
   localparam int EndCycles   = 10;
   localparam int CycleLimit  = 400000;

   logic        clock, reset;
   logic        csr_wr_en, csr_index;
   logic [15:0] csr_wr_data;
   logic        req_valid, req_stall, req_op;
   logic [7:0]  req_table_byte;
   logic        rsp_valid, rsp_stall;
   logic [1:0]  rsp_record_kind;
   logic        rsp_last_of_table;
   logic [7:0]  rsp_struct_type;
   logic [15:0] rsp_struct_handle;
   logic [2:0]  rsp_socket_code;
   logic [15:0] rsp_l1_cache_handle, rsp_l2_cache_handle, rsp_l3_cache_handle;
   logic [1:0]  rsp_cache_kind;
   logic [20:0] rsp_cache_size_kb;

   int          fail_count, records_owed;
   int          random_items;
   int unsigned cycle_count;
   bit          gaps_on, hold_request;
   logic [7:0]  table_image[$];

   smbios_structure_walker u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_table_byte      (req_table_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_record_kind     (rsp_record_kind),
      .rsp_last_of_table   (rsp_last_of_table),
      .rsp_struct_type     (rsp_struct_type),
      .rsp_struct_handle   (rsp_struct_handle),
      .rsp_socket_code     (rsp_socket_code),
      .rsp_l1_cache_handle (rsp_l1_cache_handle),
      .rsp_l2_cache_handle (rsp_l2_cache_handle),
      .rsp_l3_cache_handle (rsp_l3_cache_handle),
      .rsp_cache_kind      (rsp_cache_kind),
      .rsp_cache_size_kb   (rsp_cache_size_kb)
   );

   smbios_record_checker u_check (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_table_byte      (req_table_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_record_kind     (rsp_record_kind),
      .rsp_last_of_table   (rsp_last_of_table),
      .rsp_struct_type     (rsp_struct_type),
      .rsp_struct_handle   (rsp_struct_handle),
      .rsp_socket_code     (rsp_socket_code),
      .rsp_l1_cache_handle (rsp_l1_cache_handle),
      .rsp_l2_cache_handle (rsp_l2_cache_handle),
      .rsp_l3_cache_handle (rsp_l3_cache_handle),
      .rsp_cache_kind      (rsp_cache_kind),
      .rsp_cache_size_kb   (rsp_cache_size_kb),
      .fail_count          (fail_count),
      .records_owed        (records_owed)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL smbios_structure_walker");
      $finish;
   end

   // Receiver: short random stalls, or one long hold when asked for
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Called and returning at a falling edge; holds the item until accepted
   task automatic send_item(logic op, logic [7:0] b);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_table_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure_walk(logic [15:0] len, logic [15:0] lim);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TABLE_LENGTH;
      csr_wr_data <= len;
      @(negedge clock);
      csr_index <= CSR_STRUCTURE_LIMIT;
      csr_wr_data <= lim;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Pause the sender until every record is out and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (records_owed != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic send_image(int restart_at);
      send_item(OP_BEGIN, 8'($urandom));
      foreach (table_image[i]) begin
         if (i == restart_at) send_item(OP_BEGIN, 8'($urandom));
         send_item(OP_BYTE, table_image[i]);
      end
   endtask

   function automatic logic [7:0] field_fill(logic [7:0] stype, int off);
      if (stype == TYPE_PROCESSOR && off == OFF_SOCKET)
         return 8'($urandom_range(SOCKET_FIRST - 1, SOCKET_LAST + 1));
      if (stype == TYPE_PROCESSOR && off > OFF_SOCKET && off <= OFF_L3_HI
          && $urandom_range(0, 3) == 0)
         return NO_HANDLE[7:0];
      if (stype == TYPE_CACHE && off == OFF_CACHE_KIND)
         return 8'($urandom_range(KIND_FIRST - 1, KIND_LAST + 1));
      if ($urandom_range(0, 7) == 0) return 8'h00;
      return 8'($urandom);
   endfunction

   task automatic append_structure(logic [7:0] stype, logic [7:0] hlen, logic [15:0] handle,
                                   int n_str, int str_min, int str_max);
      int flen;
      flen = (hlen < MIN_HEADER) ? MIN_HEADER : hlen;
      table_image.push_back(stype);
      table_image.push_back(hlen);
      table_image.push_back(handle[7:0]);
      table_image.push_back(handle[15:8]);
      for (int off = MIN_HEADER; off < flen; off++) table_image.push_back(field_fill(stype, off));
      for (int s = 0; s < n_str; s++) begin
         repeat ($urandom_range(str_min, str_max))
            table_image.push_back(8'($urandom_range(1, 255)));
         table_image.push_back(8'h00);
      end
      if (n_str == 0) table_image.push_back(8'h00);
      table_image.push_back(8'h00);
   endtask

   task automatic random_structure();
      logic [7:0] stype, hlen;
      int         pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         stype = TYPE_PROCESSOR;
         hlen = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 'h1f))
                                            : 8'($urandom_range('h20, 'h2a));
      end else if (pick < 7) begin
         stype = TYPE_CACHE;
         hlen = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 'h12))
                                            : 8'($urandom_range('h13, 'h1b));
      end else begin
         stype = 8'($urandom);
         hlen = 8'($urandom_range(0, 'h20));
      end
      // now and then a structure long enough to run the offset into saturation
      if ($urandom_range(0, 24) == 0)
         append_structure(stype, 8'($urandom_range('he0, 'hff)), 16'($urandom), 3, 30, 40);
      else
         append_structure(stype, hlen, 16'($urandom), $urandom_range(0, 3), 1, 6);
   endtask

   task automatic walk_table();
      int n, total, len, lim, restart_at;
      table_image.delete();
      n = $urandom_range(1, 4);
      repeat (n) random_structure();
      total = table_image.size();
      lim = ($urandom_range(0, 7) == 0) ? 'hffff : $urandom_range(1, n + 1);
      case ($urandom_range(0, 4))
         0: len = total;
         1: len = total + $urandom_range(1, 3);
         2: len = total + $urandom_range(4, 12);
         3: len = $urandom_range(MIN_HEADER, total);
         default: begin
            len = 'hffff;
            lim = $urandom_range(1, n);
         end
      endcase
      if ($urandom_range(0, 19) == 0) len = $urandom_range(0, MIN_HEADER - 1);
      else if ($urandom_range(0, 29) == 0) lim = 0;
      // pad with noise to two bytes past the table end, but no more than 14 bytes past the structures
      while (table_image.size() < len + 2 && table_image.size() < total + 14)
         table_image.push_back(8'($urandom));
      restart_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, table_image.size() - 1) : -1;
      settle();
      configure_walk(16'(len), 16'(lim));
      if (gaps_on && $urandom_range(0, 5) == 0) hold_request = 1'b1;
      send_image(restart_at);
      random_items += 1 + table_image.size() + ((restart_at >= 0) ? 1 : 0);
   endtask

   // Hold the receiver while begins on a short table pile up empty records
   task automatic flood_while_held();
      settle();
      configure_walk(16'($urandom_range(0, MIN_HEADER - 1)), 16'($urandom));
      hold_request = 1'b1;
      repeat (12) begin
         send_item(OP_BEGIN, 8'($urandom));
         random_items++;
      end
   endtask

   initial begin
      int tables;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_TABLE_LENGTH;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_op = OP_BEGIN;
      req_table_byte = '0;
      gaps_on = 1'b1;
      hold_request = 1'b0;
      random_items = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // table shorter than a header, then a byte while idle
      configure_walk(16'd3, 16'hffff);
      send_item(OP_BEGIN, 8'h00);
      send_item(OP_BYTE, 8'hff);
      // structure limit of zero
      settle();
      configure_walk(16'hffff, 16'd0);
      send_item(OP_BEGIN, 8'hff);
      // header length below 4, limit reached on the first structure
      settle();
      configure_walk(16'hffff, 16'd1);
      table_image = '{8'hff, 8'h02, 8'hff, 8'hff, 8'h00, 8'h00};
      send_image(-1);
      // table ends inside the header
      settle();
      configure_walk(16'd5, 16'hffff);
      table_image = '{TYPE_PROCESSOR, 8'h20, 8'h34, 8'h12, 8'h00};
      send_image(-1);
      settle();
      configure_walk(16'd4, 16'd2);
      table_image = '{8'h00, 8'h00, 8'h00, 8'h00};
      send_image(-1);

      tables = 0;
      while (random_items < 400 || tables < 3) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         if (tables == 2) flood_while_held();
         else walk_table();
         tables++;
      end
      gaps_on = 1'b0;
      repeat (3) walk_table();

      settle();
      repeat (EndCycles) @(negedge clock);
      if (fail_count == 0 && records_owed == 0)
         $display("PASS smbios_structure_walker");
      else
         $display("FAIL smbios_structure_walker");
      $finish;
   end

endmodule

// ===== sim.f =====
src/ssw_pkg.sv
src/ssw_front.sv
src/ssw_queue.sv
src/ssw_back.sv
src/smbios_structure_walker.sv
tb/sv/smbios_record_checker.sv
tb/sv/tb.sv
